/* sv/cfir_pkg.sv */
// Shared types and constants for the causal FIR filter.
// No dependencies; imported by the controller, datapath and top level.
package cfir_pkg;

  // Beat widths on the streams
  localparam int unsigned IN_TDATA_W  = 24;  // coef_index(6) + data_value(16), padded
  localparam int unsigned OUT_TDATA_W = 40;  // filtered_value(38), padded
  localparam int unsigned ACC_W       = 38;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned TAPCNT_W    = 7;

  // Item kinds carried on in_tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Register map
  localparam logic REG_TAP_COUNT = 1'b0;  // paddr[2]
  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 7'd40;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_MAC,
    S_DRAIN,
    S_OUT
  } cfir_state_t;

  typedef struct packed {
    logic capture;    // latch the input beat
    logic write;      // store sample or coefficient, set up the MAC pass
    logic mac_issue;  // read one tap pair
    logic out_load;   // move the accumulator to the output register
  } cfir_cmd_t;

  typedef struct packed {
    logic is_load;    // captured item is a coefficient load
    logic pipe_busy;  // MAC pipeline still holds a tap
    logic out_free;   // output register can take a result
  } cfir_stat_t;

endpackage

/* sv/cfir_ctrl.sv */
// Sequencer for the causal FIR filter: accepts beats and steps the MAC pass.
// Depends on cfir_pkg; drives cfir_dp through cfir_cmd_t.
module cfir_ctrl
  import cfir_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 64,
  localparam int unsigned CW = $clog2(MAX_TAPS + 1),
  localparam int unsigned TW = (CW > TAPCNT_W) ? CW : TAPCNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [TAPCNT_W-1:0] tap_count,
  input  cfir_stat_t          stat,
  output cfir_cmd_t           cmd,
  output logic [CW-1:0]       tap_idx
);

  cfir_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] taps_eff;

  // Clamp the tap count to the delay line length
  always_comb begin
    if (TW'(tap_count) > TW'(MAX_TAPS)) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(tap_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.is_load ? S_IDLE : S_MAC;
      end
      S_MAC: begin
        if (cnt_r == taps_eff) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.mac_issue = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign tap_idx = cnt_r;

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_issue |-> (cnt_r < taps_eff))
    else $error("tap issued past the tap count");

  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.pipe_busy)
    else $error("result taken while the MAC pipeline is busy");

  a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("not ready after emitting a result");

endmodule

/* sv/cfir_dp.sv */
// Datapath for the causal FIR filter: coefficient and history memories,
// MAC pipeline and output register. Depends on cfir_pkg; steered by cfir_ctrl.
module cfir_dp
  import cfir_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 64,
  localparam int unsigned CW = $clog2(MAX_TAPS + 1),
  localparam int unsigned AW = $clog2(MAX_TAPS),
  localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfir_cmd_t              cmd,
  input  logic [CW-1:0]          tap_idx,
  input  logic                   in_command,
  input  logic [IDX_W-1:0]       in_coef_index,
  input  logic signed [SAMPLE_W-1:0] in_data_value,
  input  logic                   in_end_of_signal,
  output cfir_stat_t             stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic signed [SAMPLE_W-1:0] wmem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hmem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        wvalid_r;

  logic                       cmd_r, eos_r;
  logic [IW-1:0]              idx_r;
  logic signed [SAMPLE_W-1:0] data_r;

  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [AW-1:0]              haddr_r;
  logic [CW-1:0]              fill_r;

  logic signed [SAMPLE_W-1:0] w_rd_r, h_rd_r, w_op, h_op;
  logic                       wv1_r, hv1_r, v1_r, v2_r;
  logic signed [31:0]         prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic signed [ACC_W-1:0]    out_data_r;
  logic                       idx_ok;

  assign ptr_nxt = (ptr_r == AW'(MAX_TAPS - 1)) ? '0 : ptr_r + 1'b1;
  assign idx_ok  = {1'b0, idx_r} < (IW + 1)'(MAX_TAPS);

  // Capture the beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      eos_r  <= in_end_of_signal;
      idx_r  <= IW'(in_coef_index);
      data_r <= in_data_value;
    end
  end

  // Memories: written on the store step, read on each tap issue
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      if (cmd_r == CMD_LOAD) begin
        if (idx_ok) begin
          wmem[idx_r[AW-1:0]] <= data_r;
        end
      end else begin
        hmem[ptr_nxt] <= data_r;
      end
    end
    if (cmd.mac_issue) begin
      w_rd_r <= wmem[tap_idx[AW-1:0]];
      h_rd_r <= hmem[haddr_r];
    end
  end

  // Control state: valid bits, write pointer, fill count, pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r    <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
      if (cmd.write) begin
        if (cmd_r == CMD_LOAD) begin
          if (idx_ok) begin
            wvalid_r[idx_r[AW-1:0]] <= 1'b1;
          end
        end else begin
          ptr_r <= ptr_nxt;
          if (fill_r < CW'(MAX_TAPS)) begin
            fill_r <= fill_r + 1'b1;
          end
        end
      end
      // Drop the history at end of signal once the result is out
      if (cmd.out_load && eos_r) begin
        fill_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk the history from newest to oldest
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      haddr_r <= ptr_nxt;
    end else if (cmd.mac_issue) begin
      haddr_r <= (haddr_r == '0) ? AW'(MAX_TAPS - 1) : haddr_r - 1'b1;
    end
    if (cmd.mac_issue) begin
      wv1_r <= wvalid_r[tap_idx[AW-1:0]];
      hv1_r <= tap_idx < fill_r;
    end
  end

  assign w_op = wv1_r ? w_rd_r : '0;
  assign h_op = hv1_r ? h_rd_r : '0;

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= w_op * h_op;
    end
    if (cmd.write) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign stat.is_load   = (cmd_r == CMD_LOAD);
  assign stat.pipe_busy = v1_r | v2_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ACC_W){1'b0}}, out_data_r};

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> v2_r)
    else $error("MAC pipeline lost a tap");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_TAPS))
    else $error("history fill count past the delay line");

  a_coef_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && cmd_r == CMD_LOAD && idx_ok) |=> wvalid_r[$past(idx_r[AW-1:0])])
    else $error("coefficient load did not mark its tap valid");

endmodule

/* sv/causal_fir_filter.sv */
// Top level of the causal direct-form FIR filter.
// Depends on cfir_pkg, cfir_ctrl and cfir_dp; holds the APB register.
//
// Usage:
//   Input stream (in_*): each beat is either a sample (in_tuser = 0) or a
//   coefficient load (in_tuser = 1). in_tdata carries coef_index in [5:0]
//   and the signed Q1.15 data_value in [21:6]. in_tlast on a sample clears
//   the sample history once that sample's result is formed.
//   Output stream (out_*): one beat per sample, the signed 38-bit sum of
//   tap products (Q8.30) in out_tdata[37:0]; loads give no output beat.
//   APB port (cfg_*): tap_count at byte address 0, 7 bits, reset 40.
//   Counts above MAX_TAPS act as MAX_TAPS; zero gives a zero result.
//   Throughput: one item at a time. A sample takes one multiply-accumulate
//   per tap through a single multiplier, with one memory read per tap from
//   each of the coefficient and history memories.
//   Reset clears all coefficients and the history to zero at once (valid
//   bits and a fill count, no clearing pass) and sets tap_count to 40.
//   When the receiver stalls, the finished result holds in the output
//   register; a further sample is accepted and computed, then waits before
//   its output step until the register frees.
module causal_fir_filter
  import cfir_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [5:0] coef_index, [21:6] data_value
  input  logic                   in_tuser,   // [0] command
  input  logic                   in_tlast,   // end_of_signal
  // Output stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [37:0] filtered_value
  // APB configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned CW = $clog2(MAX_TAPS + 1);

  logic [TAPCNT_W-1:0] tap_count_r;
  cfir_cmd_t           cmd;
  cfir_stat_t          stat;
  logic [CW-1:0]       tap_idx;
  logic                cfg_wr;

  // Register writes complete on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_TAP_COUNT) begin
      tap_count_r <= cfg_pwdata[TAPCNT_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_TAP_COUNT) begin
      cfg_prdata = {{(32 - TAPCNT_W){1'b0}}, tap_count_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  cfir_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .tap_count (tap_count_r),
    .stat      (stat),
    .cmd       (cmd),
    .tap_idx   (tap_idx)
  );

  cfir_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .tap_idx          (tap_idx),
    .in_command       (in_tuser),
    .in_coef_index    (in_tdata[IDX_W-1:0]),
    .in_data_value    (in_tdata[IDX_W+SAMPLE_W-1:IDX_W]),
    .in_end_of_signal (in_tlast),
    .stat             (stat),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for causal_fir_filter: streams samples and coefficient loads and
// checks each output beat against a built-in predictor of the filter.
// Depends on cfir_pkg and the causal_fir_filter RTL only.
module testbench;
  import cfir_pkg::*;

  localparam int unsigned MAX_TAPS      = 64;
  localparam int unsigned SETTLE_CYCLES = 80;       // outlasts the longest sample
  localparam int unsigned HOLD_CYCLES   = 500;      // long receiver stall
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned MIXED_ITEMS   = 55;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [5:0] coef_index, [21:6] data_value
  logic                   in_tuser = CMD_SAMPLE;  // [0] command
  logic                   in_tlast = 1'b0; // end_of_signal
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [37:0] filtered_value
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [2:0]             cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  causal_fir_filter #(.MAX_TAPS(MAX_TAPS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // Filter predictor state: delay line (newest at 0), coefficient bank, tap count.
  logic signed [15:0]     delay_line [MAX_TAPS];
  logic signed [15:0]     coef_bank  [MAX_TAPS];
  logic [TAPCNT_W-1:0]    taps_setting;

  // Sums still owed by the block, oldest first.
  logic [ACC_W-1:0]       sums_due [$];
  logic [ACC_W-1:0]       due_sum;

  int unsigned            mismatches = 0;
  int unsigned            cycle_count = 0;
  bit                     calm = 1'b0;            // no idling on either side while set
  int unsigned            hold_requests = 0;
  int unsigned            hold_served = 0;
  int unsigned            hold_left = 0;

  // One row of the directed stimulus; want is used only where typed is set.
  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   idx;
    logic [15:0]        level;
    logic               eos;
    logic               typed;
    logic [ACC_W-1:0]   want;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 18;

  // Runs with the reset tap count of 40 and all-zero coefficients and history.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // zero coefficients after reset give zero, whatever the sample
    '{CMD_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, 38'd0},
    // end of signal: clear the history after this sample
    '{CMD_SAMPLE, 6'd0,  16'h8000, 1'b1, 1'b1, 38'd0},
    '{CMD_LOAD,   6'd0,  16'h8000, 1'b0, 1'b0, 38'd0},
    '{CMD_LOAD,   6'd63, 16'h7FFF, 1'b0, 1'b0, 38'd0},
    '{CMD_LOAD,   6'd39, 16'h7FFF, 1'b0, 1'b0, 38'd0},
    // most negative times most negative on tap 0: 2^30
    '{CMD_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b1, 38'd1073741824},
    // end flag on a load: ignore it, keep the history
    '{CMD_LOAD,   6'd0,  16'h7FFF, 1'b1, 1'b0, 38'd0},
    '{CMD_SAMPLE, 6'd0,  16'h0000, 1'b0, 1'b1, 38'd0},
    '{CMD_LOAD,   6'd1,  16'h7FFF, 1'b0, 1'b0, 38'd0},
    '{CMD_SAMPLE, 6'd0,  16'h3039, 1'b0, 1'b0, 38'd0},
    '{CMD_SAMPLE, 6'd0,  16'hFFFF, 1'b0, 1'b0, 38'd0},
    '{CMD_LOAD,   6'd21, 16'h5555, 1'b0, 1'b0, 38'd0},
    '{CMD_LOAD,   6'd42, 16'hAAAA, 1'b0, 1'b0, 38'd0},
    '{CMD_SAMPLE, 6'd0,  16'h5555, 1'b0, 1'b0, 38'd0},
    '{CMD_SAMPLE, 6'd0,  16'hAAAA, 1'b0, 1'b0, 38'd0},
    '{CMD_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b0, 38'd0},
    // fresh signal: only tap 0 sees data, 32767 squared
    '{CMD_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, 38'd1073676289},
    '{CMD_SAMPLE, 6'd0,  16'h0001, 1'b1, 1'b0, 38'd0}
  };

  // Apply one accepted beat to the predictor; a sample yields its tap sum.
  task automatic advance_filter(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic signed [15:0] level, input logic eos,
                                output bit produced, output logic [ACC_W-1:0] sum);
    logic signed [ACC_W-1:0] acc;
    int unsigned             live_taps;
    produced = 1'b0;
    sum      = '0;
    if (cmd == CMD_LOAD) begin
      coef_bank[idx] = level;
    end else begin
      for (int m = MAX_TAPS - 1; m > 0; m--) delay_line[m] = delay_line[m-1];
      delay_line[0] = level;
      // counts above the delay line length act as the full length
      live_taps = (taps_setting > MAX_TAPS) ? MAX_TAPS : taps_setting;
      acc = '0;
      for (int m = 0; m < live_taps; m++) acc = acc + coef_bank[m] * delay_line[m];
      sum      = acc;
      produced = 1'b1;
      if (eos) begin
        for (int m = 0; m < MAX_TAPS; m++) delay_line[m] = '0;
      end
    end
  endtask

  // Offer one beat, hold it until accepted, then log what the block owes for it.
  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [15:0] level, input logic eos,
                           input logic typed, input logic [ACC_W-1:0] want);
    bit               produced;
    logic [ACC_W-1:0] sum;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - IDX_W - SAMPLE_W){1'b0}}, level, idx};
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_filter(cmd, idx, level, eos, produced, sum);
    if (produced) sums_due.push_back(typed ? want : sum);
  endtask

  // Drain every owed beat, then give a trailing load time to finish.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value once pready is seen.
  task automatic write_tap_count(input logic [TAPCNT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TAP_COUNT, 2'b00};
    cfg_pwdata  <= {{(32 - TAPCNT_W){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    taps_setting = value;
  endtask

  // Bias levels toward the extremes and zero.
  function automatic logic [15:0] pick_level();
    logic [15:0] level;
    case ($urandom_range(7))
      0:       level = 16'h8000;
      1:       level = 16'h7FFF;
      2:       level = 16'h0000;
      default: level = 16'($urandom);
    endcase
    return level;
  endfunction

  // Random traffic: mostly samples, a fifth loads, now and then an end of signal.
  task automatic run_mixed(input logic [TAPCNT_W-1:0] taps, input int unsigned count);
    write_tap_count(taps);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20)
        send_item(CMD_LOAD, 6'($urandom_range(MAX_TAPS - 1)), pick_level(),
                  1'($urandom), 1'b0, '0);
      else
        send_item(CMD_SAMPLE, 6'($urandom), pick_level(),
                  1'($urandom_range(29) == 0), 1'b0, '0);
    end
    wait_idle();
  endtask

  // Fill every tap with one extreme and feed a run of one extreme sample,
  // driving the sum to the ends of its range.
  task automatic run_extreme(input logic [TAPCNT_W-1:0] taps, input logic [15:0] coef,
                             input logic [15:0] level);
    write_tap_count(taps);
    for (int unsigned i = 0; i < MAX_TAPS; i++)
      send_item(CMD_LOAD, 6'(i), coef, 1'b0, 1'b0, '0);
    for (int unsigned i = 0; i < MAX_TAPS + 8; i++)
      send_item(CMD_SAMPLE, 6'($urandom), level, 1'(i == MAX_TAPS + 7), 1'b0, '0);
    wait_idle();
  endtask

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check every output beat against the oldest owed sum.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: filtered_value %0d",
                   $signed(out_tdata[ACC_W-1:0]));
      end else begin
        due_sum = sums_due.pop_front();
        if (out_tdata[ACC_W-1:0] !== due_sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("filtered_value mismatch: expected %0d, got %0d",
                     $signed(due_sum), $signed(out_tdata[ACC_W-1:0]));
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    for (int m = 0; m < MAX_TAPS; m++) begin
      delay_line[m] = '0;
      coef_bank[m]  = '0;
    end
    taps_setting = TAP_COUNT_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset tap count
    for (int unsigned r = 0; r < DIRECTED_ROWS; r++)
      send_item(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].level,
                directed_rows[r].eos, directed_rows[r].typed, directed_rows[r].want);
    wait_idle();

    // Zero taps: every sum is empty
    run_mixed(7'd0, 20);
    // One tap, then the full delay line with no idling at all
    run_mixed(7'd1, MIXED_ITEMS);
    calm = 1'b1;
    run_mixed(7'd64, MIXED_ITEMS);
    calm = 1'b0;

    // Long receiver hold-off while the sender keeps offering beats
    hold_requests <= hold_requests + 1;
    run_mixed(7'd33, MIXED_ITEMS);

    // Counts above the delay line length act as the full length; then 2, 63 and a random count
    run_mixed(7'd127, MIXED_ITEMS);
    run_mixed(7'd65, MIXED_ITEMS);
    run_mixed(7'd2, MIXED_ITEMS);
    run_mixed(7'd63, MIXED_ITEMS);
    run_mixed(7'($urandom_range(1, 127)), MIXED_ITEMS);

    // Largest positive and most negative sums
    run_extreme(7'd64, 16'h8000, 16'h8000);
    run_extreme(7'd127, 16'h7FFF, 16'h8000);

    run_mixed(7'd40, MIXED_ITEMS);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/cfir_pkg.sv
sv/cfir_ctrl.sv
sv/cfir_dp.sv
sv/causal_fir_filter.sv
tb/testbench.sv
